@@ src/hhlt_pkg.sv @@
package hhlt_pkg;

  // default width of the byte position counter
  localparam int unsigned OffsetBitsDef = 16;

  // register reset value
  localparam logic [15:0] MaxValueLenRst = 16'd255;

  // result status codes
  localparam logic [2:0] ST_CONSUMED = 3'd0;
  localparam logic [2:0] ST_LINE     = 3'd1;
  localparam logic [2:0] ST_DONE     = 3'd2;
  localparam logic [2:0] ST_ERROR    = 3'd3;
  localparam logic [2:0] ST_IGNORED  = 3'd4;

  // delimiter bytes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // input word
  typedef struct packed {
    logic       restart;
    logic [7:0] data_byte;
  } hhlt_in_t;

  // result word
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] byte_offset;
    logic [15:0] key_offset;
    logic [15:0] key_length;
    logic [15:0] value_offset;
    logic [15:0] value_length;
  } hhlt_out_t;

endpackage

@@ src/hhlt_parser.sv @@
module hhlt_parser import hhlt_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  hhlt_in_t    item_i,
  input  logic [15:0] max_len_i,
  output hhlt_out_t   result_o
);

  typedef enum logic [9:0] {
    PH_START  = 10'b00_0000_0001,
    PH_KEY    = 10'b00_0000_0010,
    PH_COLON  = 10'b00_0000_0100,
    PH_SPACE  = 10'b00_0000_1000,
    PH_VALUE  = 10'b00_0001_0000,
    PH_CR     = 10'b00_0010_0000,
    PH_LF     = 10'b00_0100_0000,
    PH_END_CR = 10'b00_1000_0000,
    PH_DONE   = 10'b01_0000_0000,
    PH_ERROR  = 10'b10_0000_0000
  } phase_e;

  typedef logic [OFFSET_BITS-1:0] ofs_t;

  // offsets are reported in 16 bits
  function automatic logic [15:0] fit16(ofs_t v);
    logic [OFFSET_BITS+15:0] w;
    w = {16'd0, v};
    return w[15:0];
  endfunction

  phase_e phase_q, phase_d, phase_cur;
  ofs_t   pos_q, pos_d, pos_cur;
  ofs_t   kb_q, kb_d, kb_cur;
  ofs_t   kf_q, kf_d, kf_cur;
  ofs_t   vb_q, vb_d, vb_cur;

  logic        sat;
  ofs_t        val_dist;
  logic [OFFSET_BITS+15:0] dist_w, max_w;
  logic [2:0]  status;
  ofs_t        ko, kl, vo, vl;
  logic [7:0]  b;

  // restart clears the state ahead of this byte
  always_comb begin
    if (item_i.restart) begin
      phase_cur = PH_START;
      pos_cur   = '0;
      kb_cur    = '0;
      kf_cur    = '0;
      vb_cur    = '0;
    end else begin
      phase_cur = phase_q;
      pos_cur   = pos_q;
      kb_cur    = kb_q;
      kf_cur    = kf_q;
      vb_cur    = vb_q;
    end
  end

  assign b        = item_i.data_byte;
  assign sat      = (pos_cur == '1);
  assign val_dist = pos_cur - vb_cur;
  assign dist_w   = {16'd0, val_dist};
  assign max_w    = {{OFFSET_BITS{1'b0}}, max_len_i};

  // recognizer step
  always_comb begin
    phase_d = phase_cur;
    kb_d    = kb_cur;
    kf_d    = kf_cur;
    vb_d    = vb_cur;
    status  = ST_CONSUMED;
    ko      = '0;
    kl      = '0;
    vo      = '0;
    vl      = '0;
    pos_d   = sat ? pos_cur : pos_cur + ofs_t'(1);
    priority if (phase_cur == PH_ERROR) begin
      status = ST_ERROR;
    end else if (phase_cur == PH_DONE) begin
      status = ST_DONE;
    end else if (sat) begin
      phase_d = PH_ERROR;
      status  = ST_ERROR;
    end else begin
      unique case (phase_cur)
        PH_START: begin
          if (b == CH_CR || b == CH_LF) begin
            status = ST_IGNORED;
          end else begin
            kb_d    = pos_cur;
            phase_d = PH_KEY;
          end
        end
        PH_KEY: begin
          if (b == CH_COLON) begin
            kf_d    = pos_cur;
            phase_d = PH_COLON;
          end else if (b == CH_CR || b == CH_LF) begin
            phase_d = PH_ERROR;
            status  = ST_ERROR;
          end
        end
        PH_COLON: begin
          if (b == CH_SPACE) begin
            phase_d = PH_SPACE;
          end else begin
            phase_d = PH_ERROR;
            status  = ST_ERROR;
          end
        end
        PH_SPACE: begin
          vb_d    = pos_cur;
          phase_d = PH_VALUE;
        end
        PH_VALUE: begin
          if (b == CH_CR) begin
            phase_d = PH_CR;
          end else if (dist_w > max_w) begin
            phase_d = PH_ERROR;
            status  = ST_ERROR;
          end
        end
        PH_CR: begin
          if (b == CH_LF) begin
            phase_d = PH_LF;
            status  = ST_LINE;
            ko      = kb_cur;
            kl      = kf_cur - kb_cur;
            vo      = vb_cur;
            vl      = val_dist - ofs_t'(1);
          end else begin
            phase_d = PH_ERROR;
            status  = ST_ERROR;
          end
        end
        PH_LF: begin
          if (b == CH_CR) begin
            phase_d = PH_END_CR;
          end else begin
            kb_d    = pos_cur;
            phase_d = PH_KEY;
          end
        end
        PH_END_CR: begin
          if (b == CH_LF) begin
            phase_d = PH_DONE;
            status  = ST_DONE;
          end else begin
            phase_d = PH_ERROR;
            status  = ST_ERROR;
          end
        end
        default: begin
          phase_d = PH_ERROR;
          status  = ST_ERROR;
        end
      endcase
    end
  end

  // result word
  always_comb begin
    result_o.status       = status;
    result_o.byte_offset  = fit16(pos_cur);
    result_o.key_offset   = fit16(ko);
    result_o.key_length   = fit16(kl);
    result_o.value_offset = fit16(vo);
    result_o.value_length = fit16(vl);
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      pos_q   <= '0;
      kb_q    <= '0;
      kf_q    <= '0;
      vb_q    <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      kb_q    <= kb_d;
      kf_q    <= kf_d;
      vb_q    <= vb_d;
    end
  end

endmodule

@@ src/hhlt_out_stage.sv @@
module hhlt_out_stage import hhlt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  hhlt_out_t data_i,
  output logic      ready_o,
  output logic      valid_o,
  input  logic      ready_i,
  output hhlt_out_t data_o
);

  logic      valid_q;
  hhlt_out_t data_q;

  // stage frees up when empty or draining this cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule

@@ src/http_header_line_tokenizer_core.sv @@
// path: a word accepted into the input register passes the parser into the result register
// throughput: one byte per cycle unless the output stalls, sustained by both registers
// the parser state steps once per byte through combinational logic
// reset: asynchronous active low; parser returns to start, offset zero, limit 255
// no clearing pass, the block takes words right after reset
module http_header_line_tokenizer_core import hhlt_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  hhlt_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output hhlt_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic        in_valid_q;
  hhlt_in_t    in_data_q;
  logic [15:0] max_len_q;
  logic        out_room;
  logic        advance;
  hhlt_out_t   result;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxValueLenRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  // input register
  assign advance    = in_valid_q && out_room;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  // recognizer
  hhlt_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_data_q),
    .max_len_i(max_len_q),
    .result_o (result)
  );

  // result register
  hhlt_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (in_valid_q),
    .data_i (result),
    .ready_o(out_room),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_data_o)
  );

endmodule

@@ src/hhlt_checker.sv @@
module hhlt_checker import hhlt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input hhlt_in_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input hhlt_out_t   out_data_o
);

  // status stays within its defined codes
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_CONSUMED || out_data_o.status == ST_LINE ||
                     out_data_o.status == ST_DONE || out_data_o.status == ST_ERROR ||
                     out_data_o.status == ST_IGNORED))
    else $error("status code out of range");

  // a completed line never has an empty key or value
  a_line_lengths: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_LINE) |->
      (out_data_o.key_length != 16'd0 && out_data_o.value_length != 16'd0))
    else $error("line reported with empty key or value");

  // location fields are zero unless a line completes
  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_LINE) |->
      (out_data_o.key_offset == 16'd0 && out_data_o.key_length == 16'd0 &&
       out_data_o.value_offset == 16'd0 && out_data_o.value_length == 16'd0))
    else $error("location fields set without a line");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result word changed");

  // offered input word holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(in_data_i)))
    else $error("offered input word changed before acceptance");

endmodule

bind http_header_line_tokenizer_core hhlt_checker u_hhlt_checker (.*);

@@ bench/hhlt_tokenizer_checker.sv @@
`timescale 1ns / 1ps

module hhlt_tokenizer_checker import hhlt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  hhlt_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  hhlt_out_t   out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int unsigned pending_o,
  output int unsigned fails_o,
  output int unsigned lines_o,
  output int unsigned ends_o,
  output int unsigned errors_o
);

  // recognizer phases of the shadow parser
  typedef enum logic [3:0] {
    PH_START, PH_KEY, PH_COLON, PH_SPACE, PH_VALUE,
    PH_CR, PH_LF, PH_END_CR, PH_DONE, PH_ERROR
  } phase_e;

  localparam logic [15:0] PosLimit = 16'hFFFF;

  phase_e      phase_q;
  logic [15:0] pos_q;
  logic [15:0] key_beg_q;
  logic [15:0] key_end_q;
  logic [15:0] val_beg_q;
  logic [15:0] val_limit_q;

  hhlt_out_t   want_q[$];
  hhlt_out_t   want_w;
  int unsigned fail_cnt = 0;
  int unsigned line_cnt = 0;
  int unsigned end_cnt = 0;
  int unsigned err_cnt = 0;

  function automatic void clear_parser();
    phase_q   = PH_START;
    pos_q     = '0;
    key_beg_q = '0;
    key_end_q = '0;
    val_beg_q = '0;
  endfunction

  // advance the shadow parser by one byte and return the result word it owes
  function automatic hhlt_out_t tokenize_byte(hhlt_in_t w);
    hhlt_out_t   r;
    logic [15:0] at;
    logic        fault;
    r = '0;
    fault = 1'b0;
    if (w.restart) clear_parser();
    at = pos_q;
    r.byte_offset = at;
    r.status = ST_CONSUMED;
    if (phase_q == PH_ERROR) begin
      r.status = ST_ERROR;
    end else if (phase_q == PH_DONE) begin
      r.status = ST_DONE;
    end else if (at == PosLimit) begin
      fault = 1'b1;
    end else begin
      case (phase_q)
        PH_START: begin
          if (w.data_byte == CH_CR || w.data_byte == CH_LF) begin
            r.status = ST_IGNORED;
          end else begin
            key_beg_q = at;
            phase_q = PH_KEY;
          end
        end
        PH_KEY: begin
          if (w.data_byte == CH_COLON) begin
            key_end_q = at;
            phase_q = PH_COLON;
          end else if (w.data_byte == CH_CR || w.data_byte == CH_LF) begin
            fault = 1'b1;
          end
        end
        PH_COLON: begin
          if (w.data_byte == CH_SPACE) phase_q = PH_SPACE;
          else fault = 1'b1;
        end
        PH_SPACE: begin
          val_beg_q = at;
          phase_q = PH_VALUE;
        end
        PH_VALUE: begin
          if (w.data_byte == CH_CR) phase_q = PH_CR;
          else if (at - val_beg_q > val_limit_q) fault = 1'b1;
        end
        PH_CR: begin
          if (w.data_byte == CH_LF) begin
            phase_q = PH_LF;
            r.status = ST_LINE;
            r.key_offset = key_beg_q;
            r.key_length = key_end_q - key_beg_q;
            r.value_offset = val_beg_q;
            r.value_length = at - 16'd1 - val_beg_q;
          end else begin
            fault = 1'b1;
          end
        end
        PH_LF: begin
          if (w.data_byte == CH_CR) begin
            phase_q = PH_END_CR;
          end else begin
            key_beg_q = at;
            phase_q = PH_KEY;
          end
        end
        PH_END_CR: begin
          if (w.data_byte == CH_LF) begin
            phase_q = PH_DONE;
            r.status = ST_DONE;
          end else begin
            fault = 1'b1;
          end
        end
        default: fault = 1'b1;
      endcase
    end
    if (fault) begin
      phase_q = PH_ERROR;
      r.status = ST_ERROR;
    end
    // offset counter sticks at its top value
    if (pos_q != PosLimit) pos_q = pos_q + 16'd1;
    return r;
  endfunction

  // watch all three channels, predict on accepted input words, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      val_limit_q = MaxValueLenRst;
      want_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) val_limit_q = cfg_data_i;
      if (in_valid_i && in_ready_i) want_q.push_back(tokenize_byte(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (want_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("%0t: result word with nothing expected: status %0d offset %0d",
                     $realtime, out_data_i.status, out_data_i.byte_offset);
          end
        end else begin
          want_w = want_q.pop_front();
          if (out_data_i.status !== want_w.status ||
              out_data_i.byte_offset !== want_w.byte_offset ||
              out_data_i.key_offset !== want_w.key_offset ||
              out_data_i.key_length !== want_w.key_length ||
              out_data_i.value_offset !== want_w.value_offset ||
              out_data_i.value_length !== want_w.value_length) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("%0t: mismatch, expected st %0d off %0d key %0d+%0d val %0d+%0d",
                       $realtime, want_w.status, want_w.byte_offset, want_w.key_offset,
                       want_w.key_length, want_w.value_offset, want_w.value_length);
              $display("%0t:           got      st %0d off %0d key %0d+%0d val %0d+%0d",
                       $realtime, out_data_i.status, out_data_i.byte_offset,
                       out_data_i.key_offset, out_data_i.key_length,
                       out_data_i.value_offset, out_data_i.value_length);
            end
          end
          case (want_w.status)
            ST_LINE:  line_cnt++;
            ST_DONE:  end_cnt++;
            ST_ERROR: err_cnt++;
            default: ;
          endcase
        end
      end
    end
    pending_o <= want_q.size();
    fails_o   <= fail_cnt;
    lines_o   <= line_cnt;
    ends_o    <= end_cnt;
    errors_o  <= err_cnt;
  end

endmodule

@@ bench/http_header_line_tokenizer_core_test.sv @@
`timescale 1ns / 1ps

module http_header_line_tokenizer_core_test;
  import hhlt_pkg::*;

  localparam int unsigned CycleLimit  = 1_500_000;
  localparam int unsigned DrainPad    = 4;
  localparam int unsigned RandomBytes = 1700;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  hhlt_in_t    in_word = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  hhlt_out_t   out_word;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_word = '0;
  logic        cfg_ready;

  int unsigned pending, fails, n_lines, n_ends, n_errors;
  int unsigned cycles = 0;
  int unsigned ready_hold = 0;
  int unsigned bytes_sent = 0;
  int unsigned sections = 0;
  int unsigned limit_writes = 0;
  int unsigned noise_pct = 0;
  logic        fast_mode = 1'b0;
  logic        restart_next = 1'b0;
  logic [15:0] cur_limit = MaxValueLenRst;

  always #6 clk = ~clk;

  http_header_line_tokenizer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_word)
  );

  hhlt_tokenizer_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_word),
    .pending_o   (pending),
    .fails_o     (fails),
    .lines_o     (n_lines),
    .ends_o      (n_ends),
    .errors_o    (n_errors)
  );

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (fast_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte(logic [7:0] bar_a, logic [7:0] bar_b,
                                           logic [7:0] bar_c);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == bar_a || b == bar_b || b == bar_c);
    return b;
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return MaxValueLenRst;
      default: return 16'($urandom_range(2, 40));
    endcase
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (fast_mode) begin
      out_ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= ~out_ready;
      ready_hold <= out_ready ? pause_len() : $urandom_range(0, 15);
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // offer one input word, with optional corruption, and wait for its handshake
  task automatic put_byte(logic [7:0] b);
    int unsigned gap;
    logic        rs;
    rs = restart_next;
    restart_next = 1'b0;
    if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct) begin
      b = 8'($urandom_range(0, 255));
      rs = rs | ($urandom_range(0, 7) == 0);
    end
    gap = pause_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{restart: rs, data_byte: b};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // wait until every expected result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainPad) @(posedge clk);
  endtask

  task automatic set_limit(logic [15:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_word <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit = v;
    limit_writes++;
  endtask

  // one header section: optional leading line breaks, fields, blank line, trailing junk
  task automatic send_section();
    int unsigned n_fields, key_len, val_len;
    noise_pct = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 6) : 0;
    fast_mode <= ($urandom_range(0, 9) == 0);
    repeat ($urandom_range(0, 2)) put_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    n_fields = $urandom_range(1, 4);
    repeat (n_fields) begin
      key_len = $urandom_range(1, 8);
      if (cur_limit < 64 && $urandom_range(0, 2) == 0) begin
        val_len = cur_limit + $urandom_range(0, 2);
      end else if ($urandom_range(0, 29) == 0) begin
        val_len = $urandom_range(240, 270);
      end else begin
        val_len = $urandom_range(1, 12);
      end
      if (val_len == 0) val_len = 1;
      put_byte(pick_byte(CH_CR, CH_LF, CH_LF));
      repeat (key_len - 1) put_byte(pick_byte(CH_COLON, CH_CR, CH_LF));
      put_byte(CH_COLON);
      put_byte(CH_SPACE);
      put_byte(8'($urandom_range(0, 255)));
      repeat (val_len - 1) put_byte(pick_byte(CH_CR, CH_CR, CH_CR));
      put_byte(CH_CR);
      put_byte(CH_LF);
    end
    put_byte(CH_CR);
    put_byte(CH_LF);
    repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
    sections++;
  endtask

  initial begin
    int unsigned random_goal;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // skipped line breaks, extreme key bytes, raw CR as first value byte, done is sticky
    restart_next = 1'b1;
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_COLON);
    put_byte(CH_SPACE);
    put_byte(CH_CR);
    put_byte(8'hFF);
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte("Z");
    // colon opening a key, then CR inside the key; error is sticky
    restart_next = 1'b1;
    put_byte(CH_COLON);
    put_byte(CH_CR);
    put_byte("x");
    // missing space after the colon
    restart_next = 1'b1;
    put_byte("A");
    put_byte(CH_COLON);
    put_byte("x");
    // CR in value not followed by LF
    restart_next = 1'b1;
    put_byte("A");
    put_byte(CH_COLON);
    put_byte(CH_SPACE);
    put_byte("v");
    put_byte(CH_CR);
    put_byte("x");
    // blank line broken after its CR
    restart_next = 1'b1;
    put_byte("A");
    put_byte(CH_COLON);
    put_byte(CH_SPACE);
    put_byte("v");
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte(CH_CR);
    put_byte("y");

    // zero limit: second value byte already too far
    set_limit(16'd0);
    restart_next = 1'b1;
    put_byte("k");
    put_byte(CH_COLON);
    put_byte(CH_SPACE);
    put_byte("a");
    put_byte("b");
    // limit of one: two value bytes fit
    set_limit(16'd1);
    restart_next = 1'b1;
    put_byte("k");
    put_byte(CH_COLON);
    put_byte(CH_SPACE);
    put_byte("a");
    put_byte("b");
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte(CH_CR);
    put_byte(CH_LF);

    // random header sections, mostly well formed, some corrupted
    random_goal = bytes_sent + RandomBytes;
    while (bytes_sent < random_goal) begin
      if ($urandom_range(0, 11) == 0) set_limit(pick_limit());
      restart_next = ($urandom_range(0, 9) != 0);
      send_section();
    end
    fast_mode <= 1'b0;
    noise_pct = 0;

    drain();
    $display("sent %0d bytes in %0d random sections plus directed runs, %0d limit writes",
             bytes_sent, sections, limit_writes);
    $display("checked %0d field lines, %0d header ends, %0d error words",
             n_lines, n_ends, n_errors);
    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
